// File: src/assert_macros.svh
// Assertion macros for the checker file of the BFS core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define BFS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("BFS core checker: assertion failed");

// Concurrent assertion that is also checked during reset.
`define BFS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("BFS core checker: reset assertion failed");

`endif

// File: src/bfs_pkg.sv
// Shared constants, state type and control/status structs of the BFS core.
package bfs_pkg;

    // Graph size and derived widths.
    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CFG_W        = 6;
    localparam int MODE_W       = 2;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(32);

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DEQ,
        ST_FETCH,
        ST_SCAN,
        ST_OUT_RD,
        ST_OUT_SHOW
    } bfs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_adj;
        logic add_edge;
        logic load_src;
        logic start_search;
        logic deq;
        logic fetch;
        logic discover;
        logic out_init;
        logic out_read;
        logic out_next;
    } bfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic src_ok;
        logic queue_empty;
        logic cand_empty;
        logic out_last;
    } bfs_sts_t;

endpackage

// File: src/bfs_ctrl.sv
// Controller state machine of the BFS core.
module bfs_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [bfs_pkg::MODE_W-1:0]   s_mode,
    output logic                         s_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  bfs_pkg::bfs_sts_t            sts,
    output bfs_pkg::bfs_cmd_t            cmd
);

    bfs_pkg::bfs_state_t state_reg;
    bfs_pkg::bfs_state_t state_next;
    logic                in_xfer;

    assign in_xfer = s_valid && s_ready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfs_pkg::ST_IDLE: begin
                if (in_xfer && (s_mode == bfs_pkg::MODE_RUN)) begin
                    state_next = bfs_pkg::ST_START;
                end
            end
            bfs_pkg::ST_START: begin
                state_next = sts.src_ok ? bfs_pkg::ST_DEQ : bfs_pkg::ST_OUT_RD;
            end
            bfs_pkg::ST_DEQ: begin
                state_next = sts.queue_empty ? bfs_pkg::ST_OUT_RD : bfs_pkg::ST_FETCH;
            end
            bfs_pkg::ST_FETCH: begin
                state_next = bfs_pkg::ST_SCAN;
            end
            bfs_pkg::ST_SCAN: begin
                if (sts.cand_empty) begin
                    state_next = bfs_pkg::ST_DEQ;
                end
            end
            bfs_pkg::ST_OUT_RD: begin
                state_next = bfs_pkg::ST_OUT_SHOW;
            end
            bfs_pkg::ST_OUT_SHOW: begin
                if (m_ready) begin
                    state_next = sts.out_last ? bfs_pkg::ST_IDLE : bfs_pkg::ST_OUT_RD;
                end
            end
            default: begin
                state_next = bfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and command decode.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            bfs_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.clear_adj = in_xfer && (s_mode == bfs_pkg::MODE_CLEAR);
                cmd.add_edge  = in_xfer && (s_mode == bfs_pkg::MODE_ADD);
                cmd.load_src  = in_xfer && (s_mode == bfs_pkg::MODE_RUN);
            end
            bfs_pkg::ST_START: begin
                cmd.start_search = 1'b1;
                cmd.out_init     = 1'b1;
            end
            bfs_pkg::ST_DEQ: begin
                cmd.deq = !sts.queue_empty;
            end
            bfs_pkg::ST_FETCH: begin
                cmd.fetch = 1'b1;
            end
            bfs_pkg::ST_SCAN: begin
                cmd.discover = !sts.cand_empty;
            end
            bfs_pkg::ST_OUT_RD: begin
                cmd.out_read = 1'b1;
            end
            bfs_pkg::ST_OUT_SHOW: begin
                m_valid      = 1'b1;
                cmd.out_next = m_ready && !sts.out_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: src/bfs_dpath.sv
// Datapath of the BFS core: graph, visited mask, queue and result stores.
module bfs_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bfs_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [bfs_pkg::VTX_W-1:0]    s_edge_from,
    input  logic [bfs_pkg::VTX_W-1:0]    s_edge_to,
    input  logic [bfs_pkg::VTX_W-1:0]    s_source_vertex,
    input  bfs_pkg::bfs_cmd_t            cmd,
    output bfs_pkg::bfs_sts_t            sts,
    output logic [bfs_pkg::VTX_W-1:0]    m_vertex,
    output logic                         m_reachable,
    output logic [bfs_pkg::VTX_W-1:0]    m_hop_distance,
    output logic [bfs_pkg::VTX_W-1:0]    m_predecessor,
    output logic                         m_last
);

    localparam int NV = bfs_pkg::MAX_VERTICES;
    localparam int VW = bfs_pkg::VTX_W;
    localparam int CW = bfs_pkg::CNT_W;

    logic [bfs_pkg::CFG_W-1:0] vcount_reg;
    logic [CW-1:0]             n_eff;
    logic [NV-1:0]             in_range;

    logic [NV-1:0]             adj_reg [NV];
    logic [NV-1:0]             vis_reg;
    logic [NV-1:0]             cand_reg;
    logic [VW-1:0]             src_reg;
    logic [VW-1:0]             v_reg;
    logic [CW-1:0]             head_reg;
    logic [CW-1:0]             tail_reg;
    logic [VW-1:0]             out_idx_reg;

    logic [VW-1:0]             queue_mem  [NV];
    logic [VW-1:0]             hop_mem    [NV];
    logic [VW-1:0]             parent_mem [NV];
    logic [VW-1:0]             q_rd_reg;
    logic [VW-1:0]             hop_rd_reg;
    logic [VW-1:0]             parent_rd_reg;

    logic [NV-1:0]             pick_oh;
    logic [VW-1:0]             pick_idx;
    logic                      edge_ok;
    logic                      q_wr_en;
    logic [VW-1:0]             q_wr_addr;
    logic [VW-1:0]             q_wr_data;
    logic                      hp_wr_en;
    logic [VW-1:0]             hp_wr_addr;
    logic [VW-1:0]             hop_wr_data;
    logic [VW-1:0]             parent_wr_data;
    logic                      hop_rd_en;
    logic [VW-1:0]             hop_rd_addr;

    // Vertex count register, written by the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= bfs_pkg::VCOUNT_RESET;
        end else if (cfg_wr_en) begin
            vcount_reg <= cfg_wr_data;
        end
    end

    // Effective vertex count: zero counts as one, large values saturate.
    always_comb begin
        if (vcount_reg == '0) begin
            n_eff = CW'(1);
        end else if (CW'(vcount_reg) > CW'(NV)) begin
            n_eff = CW'(NV);
        end else begin
            n_eff = CW'(vcount_reg);
        end
    end

    // Mask of the vertex indices that are in use.
    always_comb begin
        for (int w = 0; w < NV; w++) begin
            in_range[w] = (CW'(w) < n_eff);
        end
    end

    assign edge_ok = (CW'(s_edge_from) < n_eff) && (CW'(s_edge_to) < n_eff);

    // Adjacency matrix, one row per tail vertex.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_adj) begin
            for (int r = 0; r < NV; r++) begin
                adj_reg[r] <= '0;
            end
        end else if (cmd.add_edge && edge_ok) begin
            adj_reg[s_edge_from][s_edge_to] <= 1'b1;
        end
    end

    // Lowest pending neighbor of the vertex being expanded.
    assign pick_oh = cand_reg & (~cand_reg + NV'(1));

    always_comb begin
        pick_idx = '0;
        for (int w = 0; w < NV; w++) begin
            if (pick_oh[w]) begin
                pick_idx = pick_idx | VW'(w);
            end
        end
    end

    // Search control registers: visited mask, candidates, queue pointers, result index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_reg     <= '0;
            cand_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            out_idx_reg <= '0;
        end else begin
            if (cmd.start_search) begin
                head_reg <= '0;
                if (sts.src_ok) begin
                    vis_reg  <= NV'(1) << src_reg;
                    tail_reg <= CW'(1);
                end else begin
                    vis_reg  <= '0;
                    tail_reg <= '0;
                end
            end
            if (cmd.deq) begin
                head_reg <= head_reg + CW'(1);
            end
            if (cmd.fetch) begin
                cand_reg <= adj_reg[q_rd_reg] & ~vis_reg & in_range;
            end
            if (cmd.discover) begin
                vis_reg  <= vis_reg | pick_oh;
                cand_reg <= cand_reg & ~pick_oh;
                tail_reg <= tail_reg + CW'(1);
            end
            if (cmd.out_init) begin
                out_idx_reg <= '0;
            end
            if (cmd.out_next) begin
                out_idx_reg <= out_idx_reg + VW'(1);
            end
        end
    end

    // Payload registers of the search.
    always_ff @(posedge aclk) begin
        if (cmd.load_src) begin
            src_reg <= s_source_vertex;
        end
        if (cmd.fetch) begin
            v_reg <= q_rd_reg;
        end
    end

    // Vertex queue: the source goes to the first slot, later vertices to the tail.
    assign q_wr_en   = (cmd.start_search && sts.src_ok) || cmd.discover;
    assign q_wr_addr = cmd.start_search ? '0 : tail_reg[VW-1:0];
    assign q_wr_data = cmd.discover ? pick_idx : src_reg;

    always_ff @(posedge aclk) begin
        if (q_wr_en) begin
            queue_mem[q_wr_addr] <= q_wr_data;
        end
        if (cmd.deq) begin
            q_rd_reg <= queue_mem[head_reg[VW-1:0]];
        end
    end

    // Hop and parent stores share one write address.
    assign hp_wr_en       = (cmd.start_search && sts.src_ok) || cmd.discover;
    assign hp_wr_addr     = cmd.discover ? pick_idx : src_reg;
    assign hop_wr_data    = cmd.discover ? (hop_rd_reg + VW'(1)) : '0;
    assign parent_wr_data = cmd.discover ? v_reg : src_reg;
    assign hop_rd_en      = cmd.fetch || cmd.out_read;
    assign hop_rd_addr    = cmd.fetch ? q_rd_reg : out_idx_reg;

    always_ff @(posedge aclk) begin
        if (hp_wr_en) begin
            hop_mem[hp_wr_addr]    <= hop_wr_data;
            parent_mem[hp_wr_addr] <= parent_wr_data;
        end
        if (hop_rd_en) begin
            hop_rd_reg <= hop_mem[hop_rd_addr];
        end
        if (cmd.out_read) begin
            parent_rd_reg <= parent_mem[out_idx_reg];
        end
    end

    // Status back to the controller.
    assign sts.src_ok      = (CW'(src_reg) < n_eff);
    assign sts.queue_empty = (head_reg == tail_reg);
    assign sts.cand_empty  = (cand_reg == '0);
    assign sts.out_last    = ((CW'(out_idx_reg) + CW'(1)) == n_eff);

    // Result fields; unreached vertices report zero distance and predecessor.
    assign m_vertex       = out_idx_reg;
    assign m_reachable    = vis_reg[out_idx_reg];
    assign m_hop_distance = m_reachable ? hop_rd_reg : '0;
    assign m_predecessor  = m_reachable ? parent_rd_reg : '0;
    assign m_last         = sts.out_last;

endmodule

// File: src/bfs_unweighted_shortest_path_core.sv
// Top level of the breadth-first search shortest-path core.
//
// Input channel (s_valid/s_ready) takes one command per transfer: clear the
// graph, add a directed edge, or run a search from s_source_vertex. Clear and
// add edge give no result. A run gives one result transfer per vertex in use, in
// index order, with m_last on the final one. The user sets the vertex count
// via cfg_wr_en/cfg_wr_data only while idle; the core does not enforce this.
//
// Run steps: seeding the search, then for each reached vertex a queue read,
// a row fetch and scan steps, each discovering one new neighbor, until the
// scan finds no neighbor left, then a check that finds the queue empty, then
// for each result a store read, after which the result is shown until the
// receiver takes it. A source out of range skips the queue steps. The queue
// and store read ports and the single discovery per cycle set this order.
// Only one command is in work at a time; s_ready is low during a run.
//
// Reset clears the graph and sets the vertex count to 32. While the
// receiver holds m_ready low, the current result stays on m_* unchanged.
module bfs_unweighted_shortest_path_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bfs_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bfs_pkg::MODE_W-1:0]   s_mode,
    input  logic [bfs_pkg::VTX_W-1:0]    s_edge_from,
    input  logic [bfs_pkg::VTX_W-1:0]    s_edge_to,
    input  logic [bfs_pkg::VTX_W-1:0]    s_source_vertex,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bfs_pkg::VTX_W-1:0]    m_vertex,
    output logic                         m_reachable,
    output logic [bfs_pkg::VTX_W-1:0]    m_hop_distance,
    output logic [bfs_pkg::VTX_W-1:0]    m_predecessor,
    output logic                         m_last
);

    bfs_pkg::bfs_cmd_t cmd;
    bfs_pkg::bfs_sts_t sts;

    // Controller.
    bfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath.
    bfs_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_edge_from     (s_edge_from),
        .s_edge_to       (s_edge_to),
        .s_source_vertex (s_source_vertex),
        .cmd             (cmd),
        .sts             (sts),
        .m_vertex        (m_vertex),
        .m_reachable     (m_reachable),
        .m_hop_distance  (m_hop_distance),
        .m_predecessor   (m_predecessor),
        .m_last          (m_last)
    );

endmodule

// File: src/bfs_checker.sv
// Port-level assertion checker of the BFS core and its bind statement.
`include "assert_macros.svh"

module bfs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [bfs_pkg::VTX_W-1:0]    m_vertex,
    input logic                         m_reachable,
    input logic [bfs_pkg::VTX_W-1:0]    m_hop_distance,
    input logic [bfs_pkg::VTX_W-1:0]    m_predecessor,
    input logic                         m_last
);

    // A stalled result holds its payload.
    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_vertex) && $stable(m_hop_distance)
            && $stable(m_predecessor);
    endproperty

    // An unreached vertex reports zero distance and predecessor.
    property p_unreached_zero;
        m_valid && !m_reachable |-> m_hop_distance == '0 && m_predecessor == '0;
    endproperty

    `BFS_ASSERT(a_out_hold, aclk, aresetn, p_out_hold)

    // The core never takes a command while a result is shown.
    `BFS_ASSERT(a_no_overlap, aclk, aresetn, !(s_ready && m_valid))

    `BFS_ASSERT(a_unreached_zero, aclk, aresetn, p_unreached_zero)

    // After a result transfer that is not the last one, the run continues.
    `BFS_ASSERT(a_run_continues, aclk, aresetn, m_valid && m_ready && !m_last |=> !s_ready)

    // Reset leaves no result pending.
    `BFS_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !m_valid)

endmodule

bind bfs_unweighted_shortest_path_core bfs_checker u_bfs_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the breadth-first search shortest-path core.
`timescale 1ns / 100ps

module testbench;

    localparam int MODE_W       = bfs_pkg::MODE_W;
    localparam int VTX_W        = bfs_pkg::VTX_W;
    localparam int CFG_W        = bfs_pkg::CFG_W;
    localparam int MAX_VERTICES = bfs_pkg::MAX_VERTICES;

    // The mode value that the core ignores.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 600;
    localparam int SETTLE      = 16;
    localparam int RANDOM_GOAL = 55;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [VTX_W-1:0]  from;
        logic [VTX_W-1:0]  to;
        logic [VTX_W-1:0]  src;
        bit                after_drain;
    } graph_cmd_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             reachable;
        logic [VTX_W-1:0] hops;
        logic [VTX_W-1:0] pred;
        logic             last;
    } path_entry_t;

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                cfg_wr_en       = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data     = '0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode          = '0;
    logic [VTX_W-1:0]    s_edge_from     = '0;
    logic [VTX_W-1:0]    s_edge_to       = '0;
    logic [VTX_W-1:0]    s_source_vertex = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [VTX_W-1:0]    m_vertex;
    logic                m_reachable;
    logic [VTX_W-1:0]    m_hop_distance;
    logic [VTX_W-1:0]    m_predecessor;
    logic                m_last;

    // Pending commands, expected search results and the shadow graph.
    graph_cmd_t          cmd_queue[$];
    path_entry_t         expected_paths[$];
    logic [MAX_VERTICES-1:0] graph_rows[MAX_VERTICES];
    logic [CFG_W-1:0]    vertex_limit = bfs_pkg::VCOUNT_RESET;

    int error_count  = 0;
    int random_items = 0;
    int hold_asks    = 0;
    int hold_done    = 0;
    int hold_left    = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int pat_left     = 0;
    int idle_cycles  = 0;
    logic [15:0] stall_mask = '1;

    bfs_unweighted_shortest_path_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_edge_from     (s_edge_from),
        .s_edge_to       (s_edge_to),
        .s_source_vertex (s_source_vertex),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex        (m_vertex),
        .m_reachable     (m_reachable),
        .m_hop_distance  (m_hop_distance),
        .m_predecessor   (m_predecessor),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Count of vertices in use for a given register value.
    function automatic int used_vertices(input logic [CFG_W-1:0] cfg);
        if (cfg == 0) return 1;
        if (cfg > MAX_VERTICES) return MAX_VERTICES;
        return int'(cfg);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Breadth-first search on the shadow graph; queues one result per vertex.
    task automatic predict_search(input logic [VTX_W-1:0] src);
        int n;
        int v;
        int hop_of[MAX_VERTICES];
        int parent_of[MAX_VERTICES];
        int frontier[$];
        logic [MAX_VERTICES-1:0] seen;
        path_entry_t entry;
        n = used_vertices(vertex_limit);
        seen = '0;
        if (src < n) begin
            seen[src] = 1'b1;
            hop_of[src] = 0;
            parent_of[src] = src;
            frontier.insert(frontier.size(), int'(src));
            while (frontier.size() != 0) begin
                v = frontier[0];
                frontier.delete(0);
                for (int w = 0; w < n; w++) begin
                    if (graph_rows[v][w] && !seen[w]) begin
                        seen[w] = 1'b1;
                        hop_of[w] = hop_of[v] + 1;
                        parent_of[w] = v;
                        frontier.insert(frontier.size(), w);
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            entry.vertex    = VTX_W'(i);
            entry.reachable = seen[i];
            entry.hops      = seen[i] ? VTX_W'(hop_of[i]) : '0;
            entry.pred      = seen[i] ? VTX_W'(parent_of[i]) : '0;
            entry.last      = (i == n - 1);
            expected_paths.insert(expected_paths.size(), entry);
        end
    endtask

    // Update the shadow graph for one accepted command.
    task automatic predict_command(input graph_cmd_t cmd);
        int n;
        n = used_vertices(vertex_limit);
        case (cmd.mode)
            bfs_pkg::MODE_CLEAR: begin
                for (int r = 0; r < MAX_VERTICES; r++) graph_rows[r] = '0;
            end
            bfs_pkg::MODE_ADD: begin
                if (cmd.from < n && cmd.to < n) graph_rows[cmd.from][cmd.to] = 1'b1;
            end
            bfs_pkg::MODE_RUN: begin
                predict_search(cmd.src);
            end
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input logic [MODE_W-1:0] mode, input int from, input int to,
                             input int src, input bit after_drain);
        graph_cmd_t cmd;
        cmd.mode        = mode;
        cmd.from        = VTX_W'(from);
        cmd.to          = VTX_W'(to);
        cmd.src         = VTX_W'(src);
        cmd.after_drain = after_drain;
        cmd_queue.insert(cmd_queue.size(), cmd);
    endtask

    // Fields that a command does not use carry random values.
    task automatic clear_graph();
        queue_cmd(bfs_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, 1'b0);
    endtask

    task automatic add_edge(input int from, input int to);
        queue_cmd(bfs_pkg::MODE_ADD, from, to, $urandom, 1'b0);
    endtask

    task automatic run_from(input int src);
        queue_cmd(bfs_pkg::MODE_RUN, $urandom, $urandom, src, 1'b0);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_valid || expected_paths.size() != 0)
            @(posedge aclk);
    endtask

    // The register is written only once the core has gone quiet.
    task automatic write_vertex_count(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        vertex_limit = value;
        @(negedge aclk);
    endtask

    // One random phase: pick a size, build a graph, then search it.
    task automatic random_phase(input int phase_no);
        int pick;
        int n;
        int kind;
        int edges;
        int runs;
        int j;
        int tmp;
        int src;
        int perm[MAX_VERTICES];
        logic [CFG_W-1:0] cfg;
        pick = (phase_no == 0) ? 0 : $urandom_range(0, 9);
        case (pick)
            0:       cfg = CFG_W'(1);
            1:       cfg = CFG_W'(2);
            2:       cfg = CFG_W'(32);
            3:       cfg = CFG_W'(0);
            4:       cfg = CFG_W'($urandom_range(33, 63));
            default: cfg = CFG_W'($urandom_range(3, 31));
        endcase
        write_vertex_count(cfg);
        n = used_vertices(cfg);
        // Leaving the old graph in place now and then keeps stale edges around.
        if ($urandom_range(0, 3) != 0) begin
            clear_graph();
            random_items++;
        end
        kind = $urandom_range(0, 2);
        for (int i = 0; i < MAX_VERTICES; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        if (kind == 0) begin
            // A chain through a random ordering gives the longest hop counts.
            for (int i = 0; i < n - 1; i++) add_edge(perm[i], perm[i + 1]);
            random_items += n - 1;
            edges = $urandom_range(0, 3);
        end else begin
            edges = $urandom_range(1, (n < 12) ? 2 * n : 24);
        end
        for (int e = 0; e < edges; e++) begin
            add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
            random_items++;
        end
        // Some noise: ignored modes and edges that leave the used range.
        if ($urandom_range(0, 2) == 0)
            queue_cmd(MODE_UNUSED, $urandom, $urandom, $urandom, 1'b0);
        if (n < MAX_VERTICES && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1) == 0) add_edge($urandom_range(n, 31), $urandom_range(0, 31));
            else add_edge($urandom_range(0, 31), $urandom_range(n, 31));
        end
        runs = $urandom_range(1, 3);
        for (int r = 0; r < runs; r++) begin
            if ($urandom_range(0, 5) == 0) src = $urandom_range(0, 31);
            else if (kind == 0 && r == 0) src = perm[0];
            else src = $urandom_range(0, n - 1);
            run_from(src);
            random_items++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin : driver
        bit offer;
        offer = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_command(cmd_queue[0]);
                cmd_queue.delete(0);
            end
            if (s_valid && !s_ready) begin
                offer = 1'b1;
            end else if (gap_left != 0) begin
                gap_left--;
            end else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].after_drain && expected_paths.size() != 0)) begin
                offer = 1'b1;
                s_mode          <= cmd_queue[0].mode;
                s_edge_from     <= cmd_queue[0].from;
                s_edge_to       <= cmd_queue[0].to;
                s_source_vertex <= cmd_queue[0].src;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_valid <= offer;
    end

    // Receiver: a long hold when asked, otherwise a random stall pattern.
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_done != hold_asks) begin
                hold_done = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       stall_mask = '1;
                        1:       stall_mask = 16'($urandom | $urandom);
                        default: stall_mask = 16'($urandom);
                    endcase
                    pat_left = 16;
                end
                pat_left--;
                m_ready <= stall_mask[pat_left];
            end
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge aclk) begin : monitor
        path_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_paths.size() == 0) begin
                report_mismatch($sformatf("unexpected result for vertex %0d", m_vertex));
            end else begin
                want = expected_paths[0];
                expected_paths.delete(0);
                if (m_vertex !== want.vertex)
                    report_mismatch($sformatf("vertex: expected %0d got %0d",
                                              want.vertex, m_vertex));
                if (m_reachable !== want.reachable)
                    report_mismatch($sformatf("reachable of vertex %0d: expected %0d got %0d",
                                              want.vertex, want.reachable, m_reachable));
                if (m_hop_distance !== want.hops)
                    report_mismatch($sformatf("hops of vertex %0d: expected %0d got %0d",
                                              want.vertex, want.hops, m_hop_distance));
                if (m_predecessor !== want.pred)
                    report_mismatch($sformatf("predecessor of vertex %0d: expected %0d got %0d",
                                              want.vertex, want.pred, m_predecessor));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last of vertex %0d: expected %0d got %0d",
                                              want.vertex, want.last, m_last));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_no;
        for (int r = 0; r < MAX_VERTICES; r++) graph_rows[r] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Full size after reset: empty graph, a small graph with a self loop,
        // a back edge and a later edge to an already found vertex.
        run_from(0);
        add_edge(0, 1);
        add_edge(1, 2);
        add_edge(0, 2);
        add_edge(0, 31);
        add_edge(31, 30);
        add_edge(2, 2);
        add_edge(30, 0);
        queue_cmd(MODE_UNUSED, 31, 31, 31, 1'b0);
        run_from(0);
        run_from(31);
        clear_graph();
        run_from(31);

        // A zero count acts as one vertex; higher sources are out of range.
        write_vertex_count(CFG_W'(0));
        add_edge(0, 0);
        add_edge(0, 1);
        run_from(0);
        run_from(1);
        run_from(31);

        // Edges stored at full size stay, but a smaller count hides them.
        write_vertex_count(CFG_W'(32));
        add_edge(20, 3);
        add_edge(0, 20);
        add_edge(0, 3);
        write_vertex_count(CFG_W'(16));
        add_edge(3, 20);
        run_from(0);
        run_from(20);

        // Receiver holds off while runs pile up; then a run that waits for
        // every earlier result before it is offered.
        write_vertex_count(CFG_W'(63));
        clear_graph();
        hold_asks++;
        for (int e = 0; e < 28; e++) add_edge($urandom_range(0, 31), $urandom_range(0, 31));
        for (int r = 0; r < 4; r++) run_from($urandom_range(0, 31));
        queue_cmd(bfs_pkg::MODE_RUN, $urandom, $urandom, $urandom_range(0, 31), 1'b1);

        phase_no = 0;
        while (random_items < RANDOM_GOAL) begin
            random_phase(phase_no);
            phase_no++;
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/bfs_pkg.sv
src/bfs_ctrl.sv
src/bfs_dpath.sv
src/bfs_unweighted_shortest_path_core.sv
src/bfs_checker.sv
dv/testbench.sv
